[src/qtd_pkg.sv]
package qtd_pkg;

  localparam int unsigned FIELD_BYTES_LIMIT = 1000;
  localparam int unsigned LENGTH_DIGIT_LIMIT = 200000000;
  localparam int QTD_QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // register indexes on the config port
  localparam logic [1:0] REG_MAX_MESSAGE = 2'd0;
  localparam logic [1:0] REG_RELAY_ENABLED = 2'd1;
  localparam logic [1:0] REG_RELAY_SUFFIX = 2'd2;

  typedef enum logic [3:0] {
    PH_MSG_LEN, PH_MODE, PH_BODY, PH_BODY_COMMA, PH_SND_LEN, PH_SND_DATA,
    PH_SND_SKIP, PH_SND_COMMA, PH_LIST_LEN, PH_RCPT_LEN, PH_RCPT_DATA,
    PH_RCPT_SKIP, PH_RCPT_COMMA, PH_LIST_COMMA, PH_STOPPED
  } phase_t;

  typedef enum logic [3:0] {
    EV_BODY = 4'd0, EV_SENDER = 4'd1, EV_RCPT = 4'd2, EV_BODY_END = 4'd3,
    EV_SENDER_END = 4'd4, EV_RCPT_END = 4'd5, EV_TRANS_END = 4'd6,
    EV_PROTO_ERR = 4'd7, EV_LEN_OVF = 4'd8
  } event_kind_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_HAS_NUL = 2'd2;
  localparam logic [1:0] ST_BAD_SENDER = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;
  localparam logic [1:0] ST_NO_RCPT = 2'd3;

  typedef enum logic [1:0] {DG_DIGIT, DG_COLON, DG_PROTO, DG_OVF} digit_t;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0] data;
    logic [1:0] status;
  } event_t;

  // all results of one input byte
  typedef struct packed {
    logic two;
    event_t ev0;
    event_t ev1;
  } record_t;

  typedef struct packed {
    logic [31:0] max_message_bytes;
    logic relay_enabled;
    logic [9:0] relay_suffix_len;
  } cfg_t;

  function automatic event_t make_ev(event_kind_t k, logic [7:0] d, logic [1:0] s);
    event_t e;
    e.kind = k;
    e.data = d;
    e.status = s;
    return e;
  endfunction

  function automatic digit_t classify(logic [31:0] acc, logic [7:0] b);
    digit_t r;
    if (b == CHAR_COLON) r = DG_COLON;
    else if (acc > LENGTH_DIGIT_LIMIT) r = DG_OVF;
    else if (b < CHAR_ZERO || b > CHAR_NINE) r = DG_PROTO;
    else r = DG_DIGIT;
    return r;
  endfunction

  function automatic logic [31:0] acc_step(logic [31:0] acc, logic [7:0] b);
    logic [7:0] d;
    d = b - CHAR_ZERO;
    return (acc << 3) + (acc << 1) + {24'd0, d};
  endfunction

endpackage

[src/qtd_front.sv]
module qtd_front (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  logic [7:0] byte_in,
  input  qtd_pkg::cfg_t cfg,
  output logic push,
  output qtd_pkg::record_t rec
);
  import qtd_pkg::*;

  phase_t phase, phase_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [31:0] field_remaining, field_remaining_next;
  logic [31:0] list_remaining, list_remaining_next;
  logic crlf_mode, crlf_mode_next;
  logic carriage_return_pending, carriage_return_pending_next;
  logic [31:0] bytes_until_overflow, bytes_until_overflow_next;
  logic size_exceeded, size_exceeded_next;
  logic sender_good, sender_good_next;
  logic any_recipient_taken, any_recipient_taken_next;
  logic [1:0] recipient_verdict, recipient_verdict_next;

  logic [31:0] limit, fr_dec, lr_dec;
  logic [32:0] need;
  digit_t dc;
  logic [1:0] nev;
  logic [1:0] nput;
  event_t e0, e1;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MSG_LEN;
      length_accumulator <= '0;
      field_remaining <= '0;
      list_remaining <= '0;
      crlf_mode <= 1'b0;
      carriage_return_pending <= 1'b0;
      bytes_until_overflow <= '0;
      size_exceeded <= 1'b0;
      sender_good <= 1'b1;
      any_recipient_taken <= 1'b0;
      recipient_verdict <= '0;
    end else if (take) begin
      phase <= phase_next;
      length_accumulator <= length_accumulator_next;
      field_remaining <= field_remaining_next;
      list_remaining <= list_remaining_next;
      crlf_mode <= crlf_mode_next;
      carriage_return_pending <= carriage_return_pending_next;
      bytes_until_overflow <= bytes_until_overflow_next;
      size_exceeded <= size_exceeded_next;
      sender_good <= sender_good_next;
      any_recipient_taken <= any_recipient_taken_next;
      recipient_verdict <= recipient_verdict_next;
    end
  end

  // parse one byte
  always_comb begin
    phase_next = phase;
    length_accumulator_next = length_accumulator;
    field_remaining_next = field_remaining;
    list_remaining_next = list_remaining;
    crlf_mode_next = crlf_mode;
    carriage_return_pending_next = carriage_return_pending;
    bytes_until_overflow_next = bytes_until_overflow;
    size_exceeded_next = size_exceeded;
    sender_good_next = sender_good;
    any_recipient_taken_next = any_recipient_taken;
    recipient_verdict_next = recipient_verdict;
    limit = (cfg.max_message_bytes == 32'hffff_ffff) ? 32'hffff_fffe
                                                      : cfg.max_message_bytes;
    fr_dec = field_remaining - 32'd1;
    lr_dec = list_remaining - 32'd1;
    dc = classify(length_accumulator, byte_in);
    need = {1'b0, length_accumulator} +
           (cfg.relay_enabled ? {23'd0, cfg.relay_suffix_len} : 33'd0);
    nev = 2'd0;
    nput = 2'd0;
    e0 = make_ev(EV_BODY, 8'd0, ST_OK);
    e1 = make_ev(EV_BODY, 8'd0, ST_OK);

    unique case (phase)
      PH_MSG_LEN, PH_SND_LEN, PH_LIST_LEN: begin
        unique case (dc)
          DG_PROTO: begin
            e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
            nev = 2'd1;
            phase_next = PH_STOPPED;
          end
          DG_OVF: begin
            e0 = make_ev(EV_LEN_OVF, 8'd0, ST_OK);
            nev = 2'd1;
            phase_next = PH_STOPPED;
          end
          DG_DIGIT: length_accumulator_next = acc_step(length_accumulator, byte_in);
          DG_COLON: begin
            length_accumulator_next = '0;
            if (phase == PH_MSG_LEN) begin
              if (length_accumulator == 32'd0) begin
                e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
                nev = 2'd1;
                phase_next = PH_STOPPED;
              end else begin
                field_remaining_next = length_accumulator;
                bytes_until_overflow_next = (limit != 32'd0) ? limit + 32'd1 : 32'd0;
                phase_next = PH_MODE;
              end
            end else if (phase == PH_SND_LEN) begin
              field_remaining_next = length_accumulator;
              if (length_accumulator >= FIELD_BYTES_LIMIT) begin
                sender_good_next = 1'b0;
                phase_next = PH_SND_SKIP;
              end else begin
                phase_next = (length_accumulator != 32'd0) ? PH_SND_DATA : PH_SND_COMMA;
              end
            end else begin
              list_remaining_next = length_accumulator;
              phase_next = (length_accumulator != 32'd0) ? PH_RCPT_LEN : PH_LIST_COMMA;
            end
          end
          default: ;
        endcase
      end
      PH_MODE: begin
        field_remaining_next = fr_dec;
        phase_next = (fr_dec != 32'd0) ? PH_BODY : PH_BODY_COMMA;
        if (byte_in == CHAR_LF) begin
          crlf_mode_next = 1'b0;
          if (limit != 32'd0 && fr_dec > limit) begin
            bytes_until_overflow_next = '0;
            size_exceeded_next = 1'b1;
          end
        end else if (byte_in == CHAR_CR) begin
          crlf_mode_next = 1'b1;
        end else begin
          e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
          nev = 2'd1;
          phase_next = PH_STOPPED;
        end
      end
      PH_BODY: begin
        field_remaining_next = fr_dec;
        if (fr_dec == 32'd0) phase_next = PH_BODY_COMMA;
        if (crlf_mode) begin
          if (carriage_return_pending) begin
            carriage_return_pending_next = 1'b0;
            if (byte_in == CHAR_LF) begin
              e0 = make_ev(EV_BODY, CHAR_LF, ST_OK);
              nput = 2'd1;
            end else begin
              e0 = make_ev(EV_BODY, CHAR_CR, ST_OK);
              nput = 2'd1;
              if (byte_in == CHAR_CR && fr_dec != 32'd0) begin
                carriage_return_pending_next = 1'b1;
              end else begin
                e1 = make_ev(EV_BODY, byte_in, ST_OK);
                nput = 2'd2;
              end
            end
          end else if (byte_in == CHAR_CR && fr_dec != 32'd0) begin
            carriage_return_pending_next = 1'b1;
          end else begin
            e0 = make_ev(EV_BODY, byte_in, ST_OK);
            nput = 2'd1;
          end
          // size countdown, one step per emitted byte
          for (int i = 0; i < 2; i++) begin
            if (i < int'(nput) && bytes_until_overflow_next != 32'd0) begin
              bytes_until_overflow_next = bytes_until_overflow_next - 32'd1;
              if (bytes_until_overflow_next == 32'd0) size_exceeded_next = 1'b1;
            end
          end
        end else begin
          e0 = make_ev(EV_BODY, byte_in, ST_OK);
          nput = 2'd1;
        end
        nev = nput;
      end
      PH_BODY_COMMA, PH_SND_COMMA, PH_LIST_COMMA: begin
        nev = 2'd1;
        if (byte_in != CHAR_COMMA) begin
          e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
          phase_next = PH_STOPPED;
        end else if (phase == PH_BODY_COMMA) begin
          e0 = make_ev(EV_BODY_END, 8'd0, ST_OK);
          phase_next = PH_SND_LEN;
        end else if (phase == PH_SND_COMMA) begin
          e0 = make_ev(EV_SENDER_END, 8'd0, sender_good ? ST_OK : ST_REJECTED);
          phase_next = PH_LIST_LEN;
        end else begin
          if (size_exceeded) e0 = make_ev(EV_TRANS_END, 8'd0, ST_TOO_BIG);
          else if (!sender_good) e0 = make_ev(EV_TRANS_END, 8'd0, ST_BAD_SENDER);
          else if (!any_recipient_taken) e0 = make_ev(EV_TRANS_END, 8'd0, ST_NO_RCPT);
          else e0 = make_ev(EV_TRANS_END, 8'd0, ST_OK);
          // fresh transaction
          length_accumulator_next = '0;
          field_remaining_next = '0;
          list_remaining_next = '0;
          crlf_mode_next = 1'b0;
          carriage_return_pending_next = 1'b0;
          size_exceeded_next = 1'b0;
          sender_good_next = 1'b1;
          any_recipient_taken_next = 1'b0;
          recipient_verdict_next = '0;
          phase_next = PH_MSG_LEN;
        end
      end
      PH_SND_DATA, PH_SND_SKIP: begin
        field_remaining_next = fr_dec;
        if (phase == PH_SND_DATA) begin
          if (byte_in == 8'd0) sender_good_next = 1'b0;
          e0 = make_ev(EV_SENDER, byte_in, ST_OK);
          nev = 2'd1;
        end
        if (fr_dec == 32'd0) phase_next = PH_SND_COMMA;
      end
      PH_RCPT_LEN: begin
        list_remaining_next = lr_dec;
        unique case (dc)
          DG_PROTO: begin
            e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
            nev = 2'd1;
            phase_next = PH_STOPPED;
          end
          DG_OVF: begin
            e0 = make_ev(EV_LEN_OVF, 8'd0, ST_OK);
            nev = 2'd1;
            phase_next = PH_STOPPED;
          end
          DG_DIGIT: begin
            length_accumulator_next = acc_step(length_accumulator, byte_in);
            if (lr_dec == 32'd0) begin
              e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
              nev = 2'd1;
              phase_next = PH_STOPPED;
            end
          end
          DG_COLON: begin
            field_remaining_next = length_accumulator;
            length_accumulator_next = '0;
            if (length_accumulator >= lr_dec) begin
              e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
              nev = 2'd1;
              phase_next = PH_STOPPED;
            end else if (need >= 33'(FIELD_BYTES_LIMIT)) begin
              recipient_verdict_next = ST_TOO_LONG;
              phase_next = PH_RCPT_SKIP;
            end else begin
              recipient_verdict_next = ST_OK;
              phase_next = (length_accumulator != 32'd0) ? PH_RCPT_DATA : PH_RCPT_COMMA;
            end
          end
          default: ;
        endcase
      end
      PH_RCPT_DATA, PH_RCPT_SKIP: begin
        field_remaining_next = fr_dec;
        list_remaining_next = lr_dec;
        if (phase == PH_RCPT_DATA) begin
          if (byte_in == 8'd0) recipient_verdict_next = ST_HAS_NUL;
          e0 = make_ev(EV_RCPT, byte_in, ST_OK);
          nev = 2'd1;
        end
        if (fr_dec == 32'd0) phase_next = PH_RCPT_COMMA;
      end
      PH_RCPT_COMMA: begin
        nev = 2'd1;
        if (byte_in != CHAR_COMMA) begin
          e0 = make_ev(EV_PROTO_ERR, 8'd0, ST_OK);
          phase_next = PH_STOPPED;
        end else begin
          list_remaining_next = lr_dec;
          if (recipient_verdict == ST_OK) any_recipient_taken_next = 1'b1;
          e0 = make_ev(EV_RCPT_END, 8'd0, recipient_verdict);
          recipient_verdict_next = ST_OK;
          phase_next = (lr_dec != 32'd0) ? PH_RCPT_LEN : PH_LIST_COMMA;
        end
      end
      default: phase_next = PH_STOPPED;
    endcase
  end

  // hand the results of this byte to the queue
  assign push = take && (nev != 2'd0);
  assign rec.two = (nev == 2'd2);
  assign rec.ev0 = e0;
  assign rec.ev1 = e1;

endmodule

[src/qtd_back.sv]
module qtd_back #(
  parameter int QUEUE_DEPTH = qtd_pkg::QTD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  qtd_pkg::record_t push_rec,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output qtd_pkg::event_t out_ev,
  output logic out_last
);
  import qtd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  record_t mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic sel;
  logic pop;
  record_t head;

  assign head = mem[rd_ptr];
  assign full = (count == CW'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_ev = sel ? head.ev1 : head.ev0;
  assign out_last = sel || !head.two;
  assign pop = out_valid && out_ready && out_last;

  // record storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_rec;
  end

  // pointers, fill count and event select within a record
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      sel <= 1'b0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
      if (out_valid && out_ready) sel <= !out_last;
    end
  end

endmodule

[src/qmtp_transaction_deframer_core.sv]
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready   | byte_in
// out     | output    | out_valid/out_ready | event_kind, data_byte, status_code, last_of_run
// cfg     | input     | apb psel/penable    | paddr, pwdata, prdata
// one byte is parsed per cycle while in_ready is high; each yields zero, one or two events
// the parser pushes a byte's events as one record into a small queue, which
// drains one event per cycle while out_ready is high; a byte with two events
// leaves as two transfers. in_ready drops only when the queue is full; out_ready stalls
// touch the parser only through that queue
// rst is synchronous and clears parser state, queue and config registers
module qmtp_transaction_deframer_core #(
  parameter int QUEUE_DEPTH = qtd_pkg::QTD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] byte_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [3:0] event_kind,
  output logic [7:0] data_byte,
  output logic [1:0] status_code,
  output logic last_of_run,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import qtd_pkg::*;

  cfg_t cfg;
  logic full, push, take;
  record_t rec;
  event_t ev;
  logic [1:0] reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[3:2];

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_MAX_MESSAGE: cfg.max_message_bytes <= pwdata;
        REG_RELAY_ENABLED: cfg.relay_enabled <= pwdata[0];
        REG_RELAY_SUFFIX: cfg.relay_suffix_len <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_MAX_MESSAGE: prdata = cfg.max_message_bytes;
      REG_RELAY_ENABLED: prdata = {31'd0, cfg.relay_enabled};
      REG_RELAY_SUFFIX: prdata = {22'd0, cfg.relay_suffix_len};
      default: prdata = '0;
    endcase
  end

  assign in_ready = !full;
  assign take = in_valid && in_ready;

  qtd_front u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .byte_in(byte_in),
    .cfg(cfg),
    .push(push),
    .rec(rec)
  );

  qtd_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_rec(rec),
    .full(full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ev(ev),
    .out_last(last_of_run)
  );

  assign event_kind = ev.kind;
  assign data_byte = ev.data;
  assign status_code = ev.status;

endmodule

[bench/qtd_event_checker.sv]
`timescale 1ns / 1ps

module qtd_event_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  byte_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  event_kind,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  status_code,
  input  logic        last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          events_pending
);
  import qtd_pkg::*;

  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic        last;
  } parsed_event_t;

  // register mirror
  logic [31:0] size_limit_reg;
  logic        relay_on;
  logic [9:0]  suffix_len;

  // parser mirror
  phase_t      phase;
  logic [31:0] len_acc;
  logic [31:0] field_left;
  logic [31:0] list_left;
  logic        crlf;
  logic        cr_held;
  logic [31:0] size_countdown;
  logic        too_big;
  logic        sender_ok;
  logic        rcpt_taken;
  logic [1:0]  rcpt_status;

  parsed_event_t byte_events[$];
  parsed_event_t expected_events[$];

  task automatic clear_transaction();
    len_acc = 0;
    field_left = 0;
    list_left = 0;
    crlf = 0;
    cr_held = 0;
    too_big = 0;
    sender_ok = 1;
    rcpt_taken = 0;
    rcpt_status = ST_OK;
  endtask

  task automatic add_event(event_kind_t k, logic [7:0] d, logic [1:0] s);
    parsed_event_t e;
    e.kind = k;
    e.data = d;
    e.status = s;
    e.last = 1'b0;
    byte_events.push_back(e);
  endtask

  task automatic halt(event_kind_t k);
    add_event(k, 8'd0, ST_OK);
    phase = PH_STOPPED;
  endtask

  // one length character: digit, colon, bad char or accumulator overflow
  task automatic scan_length(input logic [7:0] b, output digit_t d);
    logic [63:0] wide;
    if (b == CHAR_COLON) d = DG_COLON;
    else if (len_acc > LENGTH_DIGIT_LIMIT) d = DG_OVF;
    else if (b < CHAR_ZERO || b > CHAR_NINE) d = DG_PROTO;
    else begin
      d = DG_DIGIT;
      wide = {32'd0, len_acc} * 64'd10 + {56'd0, b - CHAR_ZERO};
      len_acc = wide[31:0];
    end
  endtask

  task automatic body_out(input logic [7:0] b);
    if (crlf && size_countdown != 0) begin
      size_countdown = size_countdown - 1;
      if (size_countdown == 0) too_big = 1;
    end
    add_event(EV_BODY, b, ST_OK);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [31:0] lim;
    logic [63:0] need;
    logic        paired;
    digit_t      d;
    lim = (size_limit_reg == 32'hFFFFFFFF) ? 32'hFFFFFFFE : size_limit_reg;
    case (phase)
      PH_MSG_LEN: begin
        scan_length(b, d);
        if (d == DG_PROTO) halt(EV_PROTO_ERR);
        else if (d == DG_OVF) halt(EV_LEN_OVF);
        else if (d == DG_COLON) begin
          if (len_acc == 0) halt(EV_PROTO_ERR);
          else begin
            field_left = len_acc;
            len_acc = 0;
            size_countdown = (lim != 0) ? lim + 1 : 32'd0;
            phase = PH_MODE;
          end
        end
      end
      PH_MODE: begin
        field_left = field_left - 1;
        if (b == CHAR_LF || b == CHAR_CR) begin
          crlf = (b == CHAR_CR);
          if (b == CHAR_LF && lim != 0 && field_left > lim) begin
            size_countdown = 0;
            too_big = 1;
          end
          phase = (field_left != 0) ? PH_BODY : PH_BODY_COMMA;
        end else halt(EV_PROTO_ERR);
      end
      PH_BODY: begin
        field_left = field_left - 1;
        if (crlf) begin
          paired = 0;
          if (cr_held) begin
            cr_held = 0;
            if (b == CHAR_LF) begin
              body_out(CHAR_LF);
              paired = 1;
            end else body_out(CHAR_CR);
          end
          if (!paired) begin
            if (b == CHAR_CR && field_left != 0) cr_held = 1;
            else body_out(b);
          end
        end else body_out(b);
        if (field_left == 0) phase = PH_BODY_COMMA;
      end
      PH_BODY_COMMA: begin
        if (b != CHAR_COMMA) halt(EV_PROTO_ERR);
        else begin
          add_event(EV_BODY_END, 8'd0, ST_OK);
          phase = PH_SND_LEN;
        end
      end
      PH_SND_LEN: begin
        scan_length(b, d);
        if (d == DG_PROTO) halt(EV_PROTO_ERR);
        else if (d == DG_OVF) halt(EV_LEN_OVF);
        else if (d == DG_COLON) begin
          field_left = len_acc;
          len_acc = 0;
          if (field_left >= FIELD_BYTES_LIMIT) begin
            sender_ok = 0;
            phase = PH_SND_SKIP;
          end else phase = (field_left != 0) ? PH_SND_DATA : PH_SND_COMMA;
        end
      end
      PH_SND_DATA, PH_SND_SKIP: begin
        field_left = field_left - 1;
        if (phase == PH_SND_DATA) begin
          if (b == 8'd0) sender_ok = 0;
          add_event(EV_SENDER, b, ST_OK);
        end
        if (field_left == 0) phase = PH_SND_COMMA;
      end
      PH_SND_COMMA: begin
        if (b != CHAR_COMMA) halt(EV_PROTO_ERR);
        else begin
          add_event(EV_SENDER_END, 8'd0, sender_ok ? ST_OK : ST_REJECTED);
          phase = PH_LIST_LEN;
        end
      end
      PH_LIST_LEN: begin
        scan_length(b, d);
        if (d == DG_PROTO) halt(EV_PROTO_ERR);
        else if (d == DG_OVF) halt(EV_LEN_OVF);
        else if (d == DG_COLON) begin
          list_left = len_acc;
          len_acc = 0;
          phase = (list_left != 0) ? PH_RCPT_LEN : PH_LIST_COMMA;
        end
      end
      PH_RCPT_LEN: begin
        list_left = list_left - 1;
        scan_length(b, d);
        if (d == DG_PROTO) halt(EV_PROTO_ERR);
        else if (d == DG_OVF) halt(EV_LEN_OVF);
        else if (d == DG_DIGIT) begin
          if (list_left == 0) halt(EV_PROTO_ERR);
        end else begin
          field_left = len_acc;
          len_acc = 0;
          if (field_left >= list_left) halt(EV_PROTO_ERR);
          else begin
            rcpt_status = ST_OK;
            need = {32'd0, field_left} + (relay_on ? {54'd0, suffix_len} : 64'd0);
            if (need >= FIELD_BYTES_LIMIT) begin
              rcpt_status = ST_TOO_LONG;
              phase = PH_RCPT_SKIP;
            end else phase = (field_left != 0) ? PH_RCPT_DATA : PH_RCPT_COMMA;
          end
        end
      end
      PH_RCPT_DATA, PH_RCPT_SKIP: begin
        field_left = field_left - 1;
        list_left = list_left - 1;
        if (phase == PH_RCPT_DATA) begin
          if (b == 8'd0) rcpt_status = ST_HAS_NUL;
          add_event(EV_RCPT, b, ST_OK);
        end
        if (field_left == 0) phase = PH_RCPT_COMMA;
      end
      PH_RCPT_COMMA: begin
        if (b != CHAR_COMMA) halt(EV_PROTO_ERR);
        else begin
          list_left = list_left - 1;
          if (rcpt_status == ST_OK) rcpt_taken = 1;
          add_event(EV_RCPT_END, 8'd0, rcpt_status);
          rcpt_status = ST_OK;
          phase = (list_left != 0) ? PH_RCPT_LEN : PH_LIST_COMMA;
        end
      end
      PH_LIST_COMMA: begin
        if (b != CHAR_COMMA) halt(EV_PROTO_ERR);
        else begin
          // verdict priority: size, sender, recipients
          if (too_big) add_event(EV_TRANS_END, 8'd0, ST_TOO_BIG);
          else if (!sender_ok) add_event(EV_TRANS_END, 8'd0, ST_BAD_SENDER);
          else if (!rcpt_taken) add_event(EV_TRANS_END, 8'd0, ST_NO_RCPT);
          else add_event(EV_TRANS_END, 8'd0, ST_OK);
          clear_transaction();
          phase = PH_MSG_LEN;
        end
      end
      default: phase = PH_STOPPED;
    endcase
  endtask

  always @(posedge clk) begin
    parsed_event_t want;
    if (rst) begin
      size_limit_reg = 0;
      relay_on = 0;
      suffix_len = 0;
      phase = PH_MSG_LEN;
      size_countdown = 0;
      clear_transaction();
      expected_events.delete();
      mismatches = 0;
    end else begin
      // compare the event leaving the block
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected event kind=%0d data=%0d status=%0d last=%0d",
                     event_kind, data_byte, status_code, last_of_run);
        end else begin
          want = expected_events.pop_front();
          if (event_kind !== want.kind || data_byte !== want.data ||
              status_code !== want.status || last_of_run !== want.last) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("event mismatch exp kind=%0d data=%0d status=%0d last=%0d, got kind=%0d data=%0d status=%0d last=%0d",
                       want.kind, want.data, want.status, want.last,
                       event_kind, data_byte, status_code, last_of_run);
          end
        end
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MAX_MESSAGE: size_limit_reg = pwdata;
          REG_RELAY_ENABLED: relay_on = pwdata[0];
          REG_RELAY_SUFFIX: suffix_len = pwdata[9:0];
          default: ;
        endcase
      end
      // predict events of the accepted byte
      if (in_valid && in_ready) begin
        byte_events.delete();
        parse_byte(byte_in);
        if (byte_events.size() != 0) byte_events[byte_events.size() - 1].last = 1'b1;
        foreach (byte_events[i]) expected_events.push_back(byte_events[i]);
      end
    end
    events_pending = expected_events.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import qtd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  byte_in;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  event_kind;
  logic [7:0]  data_byte;
  logic [1:0]  status_code;
  logic        last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int events_pending;
  int bytes_sent;
  int cycle_count;
  bit steady;
  bit rx_hold_req;

  qmtp_transaction_deframer_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
    .out_valid(out_valid), .out_ready(out_ready), .event_kind(event_kind),
    .data_byte(data_byte), .status_code(status_code), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  qtd_event_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .byte_in(byte_in),
    .out_valid(out_valid), .out_ready(out_ready), .event_kind(event_kind),
    .data_byte(data_byte), .status_code(status_code), .last_of_run(last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .events_pending(events_pending)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("qmtp_transaction_deframer_core verification failed");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches and one long hold-off
  initial begin
    int g;
    out_ready = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ready <= 0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 0;
      end else begin
        g = steady ? 0 : $urandom_range(0, 17);
        if (g > 0) begin
          out_ready <= 0;
          repeat (g) @(posedge clk);
        end
      end
      out_ready <= 1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int g;
    g = steady ? 0 : $urandom_range(0, 17);
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    byte_in <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic int digit_count(input int unsigned n);
    int c;
    c = 1;
    while (n >= 10) begin
      n = n / 10;
      c++;
    end
    return c;
  endfunction

  task automatic send_length(input int unsigned n);
    int unsigned p;
    p = 1;
    repeat (digit_count(n) - 1) p = p * 10;
    while (p != 0) begin
      send_byte(CHAR_ZERO + 8'((n / p) % 10));
      p = p / 10;
    end
    send_byte(CHAR_COLON);
  endtask

  // field content with a fair share of NUL bytes
  function automatic logic [7:0] field_byte(input int nul_odds);
    if (nul_odds != 0 && $urandom_range(0, nul_odds - 1) == 0) return 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  // body content leaning on CR and LF
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 3))
      0: return CHAR_CR;
      1: return CHAR_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_transaction(input int body_n, input bit use_crlf, input int snd_n,
                                  input int n_rcpt, input int rcpt_max, input int nul_odds);
    int rlen[$];
    int list_n;
    list_n = 0;
    for (int i = 0; i < n_rcpt; i++) begin
      rlen.push_back($urandom_range(0, rcpt_max));
      list_n += digit_count(rlen[i]) + rlen[i] + 2;
    end
    send_length(body_n + 1);
    send_byte(use_crlf ? CHAR_CR : CHAR_LF);
    repeat (body_n) send_byte(body_byte());
    send_byte(CHAR_COMMA);
    send_length(snd_n);
    repeat (snd_n) send_byte(field_byte(nul_odds));
    send_byte(CHAR_COMMA);
    send_length(list_n);
    foreach (rlen[i]) begin
      send_length(rlen[i]);
      repeat (rlen[i]) send_byte(field_byte(nul_odds));
      send_byte(CHAR_COMMA);
    end
    send_byte(CHAR_COMMA);
  endtask

  task automatic random_transaction();
    steady = ($urandom_range(0, 3) == 0);
    send_transaction($urandom_range(0, 30), $urandom_range(0, 1), $urandom_range(0, 12),
                     $urandom_range(0, 4), $urandom_range(0, 10), 25);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic set_config(input logic [31:0] limit, input bit relay, input int suffix);
    wait_idle();
    write_reg(REG_MAX_MESSAGE, limit);
    write_reg(REG_RELAY_ENABLED, {31'd0, relay});
    write_reg(REG_RELAY_SUFFIX, 32'(suffix));
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    byte_in = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    bytes_sent = 0;
    steady = 0;
    rx_hold_req = 0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: default config, both line modes, empty fields and lists
    send_transaction(0, 0, 0, 0, 0, 0);
    send_transaction(6, 1, 3, 1, 4, 0);
    send_transaction(5, 0, 2, 2, 0, 3);
    // size limit, long sender and long recipient
    set_config(32'd3, 1'b1, 999);
    send_transaction(8, 1, 1, 2, 3, 0);
    send_transaction(8, 0, 1, 1, 1, 2);
    send_transaction(2, 0, 1000, 1, 2, 0);
    set_config(32'hFFFFFFFF, 1'b0, 0);
    send_transaction(10, 1, 4, 3, 5, 0);

    // random phases over several settings; the long sender above already
    // accounts for well over a thousand bytes
    set_config(32'd0, 1'b0, 0);
    while (bytes_sent < 1240) random_transaction();
    set_config(32'd12, 1'b1, 995);
    rx_hold_req = 1;
    steady = 1;
    while (bytes_sent < 1300) random_transaction();
    wait_idle();
    set_config(32'd1, 1'b1, 0);
    while (bytes_sent < 1340) random_transaction();
    set_config(32'hFFFFFFFE, 1'b0, 999);
    while (bytes_sent < 1380) random_transaction();
    set_config(32'd20, 1'b1, 500);
    while (bytes_sent < 1420) random_transaction();

    // length overflow stops the parser; later bytes give nothing
    steady = 0;
    repeat (10) send_byte(8'h39);
    send_byte(CHAR_COLON);
    send_byte(CHAR_COMMA);

    wait_idle();
    if (mismatches == 0) $display("qmtp_transaction_deframer_core verification clean");
    else $display("qmtp_transaction_deframer_core verification failed");
    $finish;
  end

endmodule
